// File: rtl/core/prt_pkg.sv
`default_nettype none

package prt_pkg;

    localparam int DEF_COUNT_WIDTH    = 32;
    localparam int DEF_PRESCALE_WIDTH = 16;

    localparam int DATA_WIDTH = 32;

    typedef logic [1:0] t_kind;
    typedef logic [2:0] t_reg_idx;

    // Transaction kinds.
    localparam t_kind KIND_TICK  = 2'd0;
    localparam t_kind KIND_WRITE = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;

    // Register map.
    localparam t_reg_idx REG_CTRL   = 3'd0;
    localparam t_reg_idx REG_STATUS = 3'd1;
    localparam t_reg_idx REG_EVENT  = 3'd2;
    localparam t_reg_idx REG_PSC    = 3'd3;
    localparam t_reg_idx REG_RELOAD = 3'd4;
    localparam t_reg_idx REG_COUNT  = 3'd5;

    // Control register bit positions.
    localparam int CTRL_EN_BIT   = 0;
    localparam int CTRL_OPM_BIT  = 3;
    localparam int CTRL_DOWN_BIT = 4;

    // Status and event register bit positions.
    localparam int STATUS_UIF_BIT = 0;
    localparam int EVENT_UG_BIT   = 0;

endpackage

`default_nettype wire

// File: rtl/core/prescaled_reload_timer.sv
// Channel   Valid        Stall        Payload
// input     i_in_valid   o_in_stall   i_kind, i_reg_index, i_write_data
// output    o_out_valid  i_out_stall  o_read_data, o_update_flag, o_counter_running
//
// One transaction per cycle is sustained while the output is not stalled; each
// passes through the input register and then the result register to the output.
// The timer state is updated when the input register hands its transaction on.
// Reset (i_rst_n low, synchronous) empties both registers and puts the timer
// in its reset state. A stall on the output holds the result register, and
// the input register, once full behind it, raises o_in_stall in the same cycle.
`default_nettype none

module prescaled_reload_timer
    import prt_pkg::*;
#(
    parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH,
    parameter int PRESCALE_WIDTH = DEF_PRESCALE_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_kind                 i_kind,
    input  wire t_reg_idx              i_reg_index,
    input  wire logic [DATA_WIDTH-1:0] i_write_data,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [DATA_WIDTH-1:0]      o_read_data,
    output logic                       o_update_flag,
    output logic                       o_counter_running
);

    // Input register.
    logic                  r_s1_valid;
    t_kind                 r_s1_kind;
    t_reg_idx              r_s1_idx;
    logic [DATA_WIDTH-1:0] r_s1_data;

    // Timer state.
    logic                      r_enable,    n_enable;
    logic                      r_one_pulse, n_one_pulse;
    logic                      r_down,      n_down;
    logic [PRESCALE_WIDTH-1:0] r_psc_set,   n_psc_set;
    logic [PRESCALE_WIDTH-1:0] r_psc_act,   n_psc_act;
    logic [PRESCALE_WIDTH-1:0] r_psc_cnt,   n_psc_cnt;
    logic [COUNT_WIDTH-1:0]    r_reload,    n_reload;
    logic [COUNT_WIDTH-1:0]    r_count,     n_count;
    logic                      r_pending,   n_pending;

    // Result register.
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_data, n_out_data;
    logic                  r_out_flag;
    logic                  r_out_run;

    logic in_accept;
    logic s1_fire;

    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind <= i_kind;
            r_s1_idx  <= i_reg_index;
            r_s1_data <= i_write_data;
        end
    end

    always_comb begin
        n_enable    = r_enable;
        n_one_pulse = r_one_pulse;
        n_down      = r_down;
        n_psc_set   = r_psc_set;
        n_psc_act   = r_psc_act;
        n_psc_cnt   = r_psc_cnt;
        n_reload    = r_reload;
        n_count     = r_count;
        n_pending   = r_pending;
        n_out_data  = '0;

        case (r_s1_kind)
            KIND_TICK: begin
                if (r_enable) begin
                    if (r_psc_cnt >= r_psc_act) begin
                        n_psc_cnt = '0;
                        // A wrap in either direction is an update event.
                        if ((r_down && r_count == '0) || (!r_down && r_count == r_reload)) begin
                            n_count   = r_down ? r_reload : '0;
                            n_pending = 1'b1;
                            n_psc_act = r_psc_set;
                            if (r_one_pulse) begin
                                n_enable = 1'b0;
                            end
                        end else if (r_down) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_psc_cnt = r_psc_cnt + 1'b1;
                    end
                end
            end
            KIND_WRITE: begin
                case (r_s1_idx)
                    REG_CTRL: begin
                        n_enable    = r_s1_data[CTRL_EN_BIT];
                        n_one_pulse = r_s1_data[CTRL_OPM_BIT];
                        n_down      = r_s1_data[CTRL_DOWN_BIT];
                    end
                    REG_STATUS: begin
                        // Writing one leaves the flag alone.
                        if (!r_s1_data[STATUS_UIF_BIT]) begin
                            n_pending = 1'b0;
                        end
                    end
                    REG_EVENT: begin
                        if (r_s1_data[EVENT_UG_BIT]) begin
                            n_count   = r_down ? r_reload : '0;
                            n_psc_cnt = '0;
                            n_psc_act = r_psc_set;
                            n_pending = 1'b1;
                        end
                    end
                    REG_PSC:    n_psc_set = r_s1_data[PRESCALE_WIDTH-1:0];
                    REG_RELOAD: n_reload  = r_s1_data[COUNT_WIDTH-1:0];
                    REG_COUNT:  n_count   = r_s1_data[COUNT_WIDTH-1:0];
                    default: begin
                    end
                endcase
            end
            KIND_READ: begin
                case (r_s1_idx)
                    REG_CTRL: begin
                        n_out_data[CTRL_EN_BIT]   = r_enable;
                        n_out_data[CTRL_OPM_BIT]  = r_one_pulse;
                        n_out_data[CTRL_DOWN_BIT] = r_down;
                    end
                    REG_STATUS: n_out_data[STATUS_UIF_BIT] = r_pending;
                    REG_PSC:    n_out_data = DATA_WIDTH'(r_psc_set);
                    REG_RELOAD: n_out_data = DATA_WIDTH'(r_reload);
                    REG_COUNT:  n_out_data = DATA_WIDTH'(r_count);
                    default:    n_out_data = '0;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_one_pulse <= 1'b0;
            r_down      <= 1'b0;
            r_psc_set   <= '0;
            r_psc_act   <= '0;
            r_psc_cnt   <= '0;
            r_reload    <= '1;
            r_count     <= '0;
            r_pending   <= 1'b0;
        end else if (s1_fire) begin
            r_enable    <= n_enable;
            r_one_pulse <= n_one_pulse;
            r_down      <= n_down;
            r_psc_set   <= n_psc_set;
            r_psc_act   <= n_psc_act;
            r_psc_cnt   <= n_psc_cnt;
            r_reload    <= n_reload;
            r_count     <= n_count;
            r_pending   <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data <= n_out_data;
            r_out_flag <= n_pending;
            r_out_run  <= n_enable;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_out_data;
    assign o_update_flag     = r_out_flag;
    assign o_counter_running = r_out_run;

    // The prescale counter only advances while below its active limit, and
    // the limit only changes together with a counter clear.
    a_psc_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_psc_cnt <= r_psc_act)
        else $error("prescale counter passed its active limit");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled with no transaction held");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_kind != KIND_READ) |=> o_read_data == '0)
        else $error("read data not zero for a non-read transaction");

    a_ug_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_kind == KIND_WRITE && r_s1_idx == REG_EVENT
            && r_s1_data[EVENT_UG_BIT]) |=> (r_pending && o_update_flag))
        else $error("update generation did not raise the flag");

    a_one_pulse_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_kind == KIND_TICK && r_one_pulse && !r_pending && n_pending)
            |=> !r_enable)
        else $error("one-pulse mode kept counting after an update");

endmodule

`default_nettype wire
